### design/cpp_pkg.sv
// ----------------------------------------------------------------------------
// cpp_pkg: shared constants and helpers for the camera point projector
// Register map codes, field widths, reset values and the sine table builder.
// ----------------------------------------------------------------------------
package cpp_pkg;

  // Register map, index = paddr / 4
  typedef enum logic [2:0] {
    REG_CAM_X     = 3'd0,
    REG_CAM_Y     = 3'd1,
    REG_CAM_Z     = 3'd2,
    REG_YAW       = 3'd3,
    REG_PITCH     = 3'd4,
    REG_ROLL      = 3'd5,
    REG_VIEW_DIST = 3'd6,
    REG_SCREEN    = 3'd7
  } cpp_reg_e;

  localparam int unsigned SineTableBitsDef = 10;
  localparam int unsigned CoordW           = 32;
  localparam int unsigned AngleW           = 16;
  localparam int unsigned DistW            = 24;
  localparam int unsigned PixW             = 16;
  localparam int unsigned PaddrW           = 5;

  localparam logic [DistW-1:0] ViewDistRst = 24'd3276800;
  localparam logic [31:0]      ScreenRst   = 32'h0200_0180;
  // depth of 0.1 in Q16.16
  localparam logic signed [26:0] NearLimit = 27'sd6554;

  // One quarter-wave sine entry, Q15, evaluated at elaboration
  function automatic logic [15:0] cpp_sine_entry(int unsigned i, int unsigned bits);
    longint unsigned x, x2, t, s, e;
    x  = (longint'(i) * 64'd1686629713) >> bits;
    x2 = (x * x) >> 30;
    t  = 64'd1 << 30;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 156;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 110;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 72;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 42;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 20;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 6;
    s  = (x * t) >> 30;
    e  = (s + 64'd16384) >> 15;
    if (e > 64'd32768) e = 64'd32768;
    return e[15:0];
  endfunction

endpackage

### design/camera_point_projection.sv
// Throughput: one word per cycle; the whole pipeline holds while the output
// register is full and not taken. The divide runs as nine 2-bit stages.
// Reset: asynchronous, active low; clears valids and loads register defaults.
// Trig values are registered from the angle registers.
// ----------------------------------------------------------------------------
// camera_point_projection
// Streams world points through camera offset, range check, yaw/pitch/roll
// rotation and perspective divide, giving visible flag and pixel position.
// ----------------------------------------------------------------------------
module camera_point_projection import cpp_pkg::*; #(
  parameter int unsigned SINE_TABLE_BITS = SineTableBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // config port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PaddrW-1:0]    paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  // input points
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [95:0]          s_axis_tdata,   // obj_x, obj_y, obj_z
  // results
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [31:0]          m_axis_tdata,   // screen_x, screen_y
  output logic                 m_axis_tuser    // visible
);

  localparam int unsigned B     = SINE_TABLE_BITS;
  localparam int unsigned TabN  = 1 << B;
  localparam int unsigned DivSt = 9;

  // ---------------- configuration registers ----------------
  logic signed [CoordW-1:0] cam_x_q, cam_y_q, cam_z_q;
  logic [AngleW-1:0]        yaw_q, pitch_q, roll_q;
  logic [DistW-1:0]         vdist_q;
  logic [31:0]              screen_q;
  logic                     wr_en;
  cpp_reg_e                 reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = cpp_reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q  <= '0;
      cam_y_q  <= '0;
      cam_z_q  <= '0;
      yaw_q    <= '0;
      pitch_q  <= '0;
      roll_q   <= '0;
      vdist_q  <= ViewDistRst;
      screen_q <= ScreenRst;
    end else if (wr_en) begin
      case (reg_sel)
        REG_CAM_X:     cam_x_q  <= pwdata;
        REG_CAM_Y:     cam_y_q  <= pwdata;
        REG_CAM_Z:     cam_z_q  <= pwdata;
        REG_YAW:       yaw_q    <= pwdata[AngleW-1:0];
        REG_PITCH:     pitch_q  <= pwdata[AngleW-1:0];
        REG_ROLL:      roll_q   <= pwdata[AngleW-1:0];
        REG_VIEW_DIST: vdist_q  <= pwdata[DistW-1:0];
        REG_SCREEN:    screen_q <= pwdata;
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_sel)
      REG_CAM_X:     prdata = cam_x_q;
      REG_CAM_Y:     prdata = cam_y_q;
      REG_CAM_Z:     prdata = cam_z_q;
      REG_YAW:       prdata = {16'd0, yaw_q};
      REG_PITCH:     prdata = {16'd0, pitch_q};
      REG_ROLL:      prdata = {16'd0, roll_q};
      REG_VIEW_DIST: prdata = {8'd0, vdist_q};
      REG_SCREEN:    prdata = screen_q;
      default:       prdata = '0;
    endcase
  end

  // ---------------- sine table and trig values ----------------
  logic [15:0] sin_tab [TabN+1];
  for (genvar g = 0; g <= TabN; g++) begin : g_tab
    localparam logic [15:0] Entry = cpp_sine_entry(g, B);
    assign sin_tab[g] = Entry;
  end

  function automatic logic [B:0] sin_idx(logic [15:0] a);
    logic [B:0] i;
    i = {1'b0, a[13 -: B]};
    if (a[14]) i = (B+1)'(TabN) - i;
    return i;
  endfunction

  logic [15:0] ang_yaw;
  logic [15:0] ang [6];      // sy, cy, sp, cp, sr, cr
  logic signed [16:0] trig_d [6];
  logic signed [16:0] trig_q [6];
  logic [47:0] vdsq_q;

  assign ang_yaw = 16'h4000 - yaw_q;
  assign ang[0]  = ang_yaw;
  assign ang[1]  = ang_yaw + 16'h4000;
  assign ang[2]  = pitch_q;
  assign ang[3]  = pitch_q + 16'h4000;
  assign ang[4]  = roll_q;
  assign ang[5]  = roll_q + 16'h4000;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      trig_d[k] = ang[k][15] ? -$signed({1'b0, sin_tab[sin_idx(ang[k])]})
                             :  $signed({1'b0, sin_tab[sin_idx(ang[k])]});
    end
  end

  always_ff @(posedge clk_i) begin
    trig_q <= trig_d;
    vdsq_q <= vdist_q * vdist_q;
  end

  // ---------------- pipeline control ----------------
  logic en;
  logic [9:0] v_q;
  logic out_v_q;

  assign en            = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (en) v_q <= {v_q[8:0], s_axis_tvalid};
  end

  // ---------------- stage 1: camera offset ----------------
  logic signed [32:0] dx1_q, dy1_q, dz1_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      dx1_q <= $signed({s_axis_tdata[31], s_axis_tdata[31:0]})  - $signed({cam_x_q[31], cam_x_q});
      dy1_q <= $signed({s_axis_tdata[63], s_axis_tdata[63:32]}) - $signed({cam_y_q[31], cam_y_q});
      dz1_q <= $signed({s_axis_tdata[95], s_axis_tdata[95:64]}) - $signed({cam_z_q[31], cam_z_q});
    end
  end

  // ---------------- stage 2: magnitudes, yaw products ----------------
  // past the range test every offset fits 25 bits, so they are cut there
  logic [32:0] ax, ay, az;
  logic signed [24:0] dx1s, dy1s;
  logic [DistW-1:0] ax2_q, ay2_q, az2_q;
  logic farc2_q;
  logic signed [41:0] p_dxc_q, p_dys_q, p_dxs_q, p_dyc_q;
  logic signed [24:0] dz2_q;

  assign ax   = dx1_q[32] ? 33'(-dx1_q) : 33'(dx1_q);
  assign ay   = dy1_q[32] ? 33'(-dy1_q) : 33'(dy1_q);
  assign az   = dz1_q[32] ? 33'(-dz1_q) : 33'(dz1_q);
  assign dx1s = dx1_q[24:0];
  assign dy1s = dy1_q[24:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax2_q   <= ax[DistW-1:0];
      ay2_q   <= ay[DistW-1:0];
      az2_q   <= az[DistW-1:0];
      farc2_q <= (ax > 33'(vdist_q)) || (ay > 33'(vdist_q)) || (az > 33'(vdist_q));
      p_dxc_q <= dx1s * trig_q[1];
      p_dys_q <= dy1s * trig_q[0];
      p_dxs_q <= dx1s * trig_q[0];
      p_dyc_q <= dy1s * trig_q[1];
      dz2_q   <= dz1_q[24:0];
    end
  end

  // ---------------- stage 3: squares, yaw result ----------------
  logic [47:0] sqx3_q, sqy3_q, sqz3_q;
  logic farc3_q;
  logic signed [42:0] sum_x1, sum_y1, rnd_x1, rnd_y1;
  logic signed [26:0] x1_3_q, y1_3_q;
  logic signed [24:0] dz3_q;

  assign sum_x1 = 43'(p_dxc_q) - 43'(p_dys_q);
  assign sum_y1 = 43'(p_dxs_q) + 43'(p_dyc_q);
  assign rnd_x1 = (sum_x1 + 43'sd16384) >>> 15;
  assign rnd_y1 = (sum_y1 + 43'sd16384) >>> 15;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqx3_q  <= ax2_q * ax2_q;
      sqy3_q  <= ay2_q * ay2_q;
      sqz3_q  <= az2_q * az2_q;
      farc3_q <= farc2_q;
      x1_3_q  <= rnd_x1[26:0];
      y1_3_q  <= rnd_y1[26:0];
      dz3_q   <= dz2_q;
    end
  end

  // ---------------- stage 4: distance test, pitch products ----------------
  logic [49:0] dist_sq;
  logic far4_q;
  logic signed [43:0] p_ycp_q, p_zsp_q, p_ysp_q, p_zcp_q;
  logic signed [26:0] x1_4_q;

  assign dist_sq = 50'(sqx3_q) + 50'(sqy3_q) + 50'(sqz3_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      far4_q  <= farc3_q || (dist_sq > 50'(vdsq_q));
      p_ycp_q <= y1_3_q * trig_q[3];
      p_zsp_q <= dz3_q * trig_q[2];
      p_ysp_q <= y1_3_q * trig_q[2];
      p_zcp_q <= dz3_q * trig_q[3];
      x1_4_q  <= x1_3_q;
    end
  end

  // ---------------- stage 5: pitch result ----------------
  logic signed [44:0] sum_y2, sum_z2, rnd_y2, rnd_z2;
  logic signed [26:0] y2_5_q, z2_5_q, x1_5_q;
  logic far5_q;

  assign sum_y2 = 45'(p_ycp_q) - 45'(p_zsp_q);
  assign sum_z2 = 45'(p_ysp_q) + 45'(p_zcp_q);
  assign rnd_y2 = (sum_y2 + 45'sd16384) >>> 15;
  assign rnd_z2 = (sum_z2 + 45'sd16384) >>> 15;

  always_ff @(posedge clk_i) begin
    if (en) begin
      y2_5_q <= rnd_y2[26:0];
      z2_5_q <= rnd_z2[26:0];
      x1_5_q <= x1_4_q;
      far5_q <= far4_q;
    end
  end

  // ---------------- stage 6: roll products, depth test ----------------
  logic signed [43:0] p_xcr_q, p_zsr_q, p_xsr_q, p_zcr_q;
  logic signed [26:0] y2_6_q;
  logic inv6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_xcr_q <= x1_5_q * trig_q[5];
      p_zsr_q <= z2_5_q * trig_q[4];
      p_xsr_q <= x1_5_q * trig_q[4];
      p_zcr_q <= z2_5_q * trig_q[5];
      y2_6_q  <= y2_5_q;
      inv6_q  <= far5_q || (y2_5_q <= NearLimit);
    end
  end

  // ---------------- stage 7: roll result ----------------
  logic signed [44:0] sum_x3, sum_z3, rnd_x3, rnd_z3;
  logic signed [26:0] x3_7_q, z3_7_q, y2_7_q;
  logic inv7_q;

  assign sum_x3 = 45'(p_xcr_q) - 45'(p_zsr_q);
  assign sum_z3 = 45'(p_xsr_q) + 45'(p_zcr_q);
  assign rnd_x3 = (sum_x3 + 45'sd16384) >>> 15;
  assign rnd_z3 = (sum_z3 + 45'sd16384) >>> 15;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x3_7_q <= rnd_x3[26:0];
      z3_7_q <= rnd_z3[26:0];
      y2_7_q <= y2_6_q;
      inv7_q <= inv6_q;
    end
  end

  // ---------------- stage 8: focal scale ----------------
  logic signed [16:0] hy_s;
  logic signed [43:0] mx8_q, mz8_q;
  logic [27:0] den8_q;
  logic inv8_q;

  assign hy_s = $signed({1'b0, screen_q[15:0]});

  always_ff @(posedge clk_i) begin
    if (en) begin
      mx8_q  <= hy_s * x3_7_q;
      mz8_q  <= hy_s * z3_7_q;
      den8_q <= 28'(y2_7_q[25:0]) + {1'b0, y2_7_q[25:0], 1'b0};
      inv8_q <= inv7_q;
    end
  end

  // ---------------- stage 9: rounded dividend ----------------
  // q = (2n + d) / (2d) with n = |4*hy*x|, d = 3*depth
  logic [42:0] mag_x, mag_z;
  logic [47:0] nx9_q, nz9_q;
  logic [29:0] dd9_q;
  logic negx9_q, negz9_q, inv9_q;

  assign mag_x = mx8_q[43] ? 43'(-mx8_q) : 43'(mx8_q);
  assign mag_z = mz8_q[43] ? 43'(-mz8_q) : 43'(mz8_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx9_q   <= {2'b0, mag_x, 3'b0} + 48'(den8_q);
      nz9_q   <= {2'b0, mag_z, 3'b0} + 48'(den8_q);
      dd9_q   <= {1'b0, den8_q, 1'b0};
      negx9_q <= mx8_q[43];
      negz9_q <= mz8_q[43];
      inv9_q  <= inv8_q;
    end
  end

  // ---------------- stage 10: quotient range check ----------------
  // quotients of 2^18 or more saturate the pixel anyway
  typedef struct packed {
    logic [29:0] rem_x;
    logic [17:0] low_x;
    logic [17:0] q_x;
    logic        ovf_x;
    logic        neg_x;
    logic [29:0] rem_z;
    logic [17:0] low_z;
    logic [17:0] q_z;
    logic        ovf_z;
    logic        neg_z;
    logic [29:0] dd;
    logic        inv;
  } div_t;

  div_t div_q [DivSt+1];
  // dv_q[s] marks a valid word in div_q[s+1]
  logic [DivSt-1:0] dv_q;
  logic ovfx10, ovfz10;

  assign ovfx10 = nx9_q[47:18] >= dd9_q;
  assign ovfz10 = nz9_q[47:18] >= dd9_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      div_q[0].rem_x <= ovfx10 ? '0 : nx9_q[47:18];
      div_q[0].low_x <= nx9_q[17:0];
      div_q[0].q_x   <= '0;
      div_q[0].ovf_x <= ovfx10;
      div_q[0].neg_x <= negx9_q;
      div_q[0].rem_z <= ovfz10 ? '0 : nz9_q[47:18];
      div_q[0].low_z <= nz9_q[17:0];
      div_q[0].q_z   <= '0;
      div_q[0].ovf_z <= ovfz10;
      div_q[0].neg_z <= negz9_q;
      div_q[0].dd    <= dd9_q;
      div_q[0].inv   <= inv9_q;
    end
  end

  // ---------------- divide: two quotient bits per stage ----------------
  function automatic logic [30:0] div_step(logic [29:0] rem, logic nb, logic [29:0] dd);
    logic [30:0] r2;
    r2 = {rem, nb};
    if (r2 >= {1'b0, dd}) return {1'b1, 30'(r2 - {1'b0, dd})};
    return {1'b0, r2[29:0]};
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_q <= '0;
    else if (en) dv_q <= {dv_q[DivSt-2:0], v_q[9]};
  end

  for (genvar s = 0; s < DivSt; s++) begin : g_div
    logic [30:0] sx_a, sx_b, sz_a, sz_b;
    div_t nxt;
    assign sx_a = div_step(div_q[s].rem_x, div_q[s].low_x[17], div_q[s].dd);
    assign sx_b = div_step(sx_a[29:0],     div_q[s].low_x[16], div_q[s].dd);
    assign sz_a = div_step(div_q[s].rem_z, div_q[s].low_z[17], div_q[s].dd);
    assign sz_b = div_step(sz_a[29:0],     div_q[s].low_z[16], div_q[s].dd);
    always_comb begin
      nxt       = div_q[s];
      nxt.rem_x = sx_b[29:0];
      nxt.low_x = {div_q[s].low_x[15:0], 2'b0};
      nxt.q_x   = {div_q[s].q_x[15:0], sx_a[30], sx_b[30]};
      nxt.rem_z = sz_b[29:0];
      nxt.low_z = {div_q[s].low_z[15:0], 2'b0};
      nxt.q_z   = {div_q[s].q_z[15:0], sz_a[30], sz_b[30]};
    end
    always_ff @(posedge clk_i) begin
      if (en) div_q[s+1] <= nxt;
    end
  end

  // ---------------- final: offset, saturate, output register ----------------
  div_t fin;
  logic [17:0] qx, qz;
  logic signed [19:0] sx_w, sy_w;
  logic [PixW-1:0] sx_sat, sy_sat;
  logic [PixW-1:0] sx_q, sy_q;
  logic vis_q;

  assign fin  = div_q[DivSt];
  assign qx   = fin.ovf_x ? '1 : fin.q_x;
  assign qz   = fin.ovf_z ? '1 : fin.q_z;
  assign sx_w = fin.neg_x ? $signed({4'd0, screen_q[31:16]}) - $signed({2'd0, qx})
                          : $signed({4'd0, screen_q[31:16]}) + $signed({2'd0, qx});
  assign sy_w = fin.neg_z ? $signed({4'd0, screen_q[15:0]}) + $signed({2'd0, qz})
                          : $signed({4'd0, screen_q[15:0]}) - $signed({2'd0, qz});
  assign sx_sat = (sx_w > 20'sd32767)  ? 16'h7FFF :
                  (sx_w < -20'sd32768) ? 16'h8000 : sx_w[15:0];
  assign sy_sat = (sy_w > 20'sd32767)  ? 16'h7FFF :
                  (sy_w < -20'sd32768) ? 16'h8000 : sy_w[15:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (en) out_v_q <= dv_q[DivSt-1];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vis_q <= !fin.inv;
      sx_q  <= fin.inv ? '0 : sx_sat;
      sy_q  <= fin.inv ? '0 : sy_sat;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {sy_q, sx_q};
  assign m_axis_tuser  = vis_q;

endmodule

### verif/tb_camera_point_projection.sv
// ----------------------------------------------------------------------------
// tb_camera_point_projection: self-checking bench for the point projector
// Drives world points through the input stream under several camera settings
// and handshake pressure phases. A local fixed-point projector or the directed
// row predicts each accepted word, checked field by field against the output.
// ----------------------------------------------------------------------------
module tb_camera_point_projection import cpp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TabBits    = 10;
  localparam int TabN       = 1 << TabBits;
  localparam int WatchLimit = 4000;
  localparam int DrainWait  = 40;
  localparam int NumPhases  = 7;
  localparam int PhaseItems = 215;

  typedef struct packed {
    logic               vis;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
  } pixel_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               typed;
    pixel_t             pix;
  } point_row_t;

  logic clk_i, rst_ni;
  logic psel, penable, pwrite;
  logic [PaddrW-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic s_axis_tvalid, s_axis_tready;
  logic [95:0] s_axis_tdata;     // obj_x, obj_y, obj_z
  logic m_axis_tvalid, m_axis_tready;
  logic [31:0] m_axis_tdata;     // screen_x, screen_y
  logic m_axis_tuser;            // visible

  camera_point_projection dut (.*);

  // shadow of the camera registers
  logic signed [31:0] cam_pos [3];
  logic [15:0]        cam_ang [3];   // yaw, pitch, roll
  logic [23:0]        view_dist;
  logic [31:0]        screen_ctr;

  int          sine_q15 [TabN+1];
  pixel_t      pixel_q [$];
  int          errors;
  int          idle_in_pct, stall_out_pct;
  int          quiet_cycles;
  point_row_t  dir_rows [13];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // quarter-wave sine, Q15, from the Taylor-style recurrence
  function automatic void fill_sine_table();
    longint unsigned x, x2, t, s, e;
    longint unsigned divs [6];
    divs = '{156, 110, 72, 42, 20, 6};
    for (int i = 0; i <= TabN; i++) begin
      x  = (longint'(i) * 64'd1686629713) >> TabBits;
      x2 = (x * x) >> 30;
      t  = 64'd1 << 30;
      for (int k = 0; k < 6; k++) t = (64'd1 << 30) - ((x2 * t) >> 30) / divs[k];
      s = (x * t) >> 30;
      e = (s + 64'd16384) >> 15;
      if (e > 64'd32768) e = 64'd32768;
      sine_q15[i] = int'(e);
    end
  endfunction

  function automatic longint bin_sin(logic [15:0] a);
    int idx;
    longint v;
    idx = int'(a[13:14-TabBits]);
    if (a[14]) idx = TabN - idx;
    v = sine_q15[idx];
    return a[15] ? -v : v;
  endfunction

  // round a Q16.16*Q15 sum back to Q16.16, to nearest with halves rounded up
  function automatic longint q15_round(longint v);
    return (v + 16384) >>> 15;
  endfunction

  function automatic longint div_nearest(longint num, longint den);
    longint unsigned n, q;
    n = (num < 0) ? longint'(-num) : num;
    q = (2 * n + den) / (2 * den);
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return -16'sh8000;
    return v[15:0];
  endfunction

  function automatic pixel_t project_point(logic signed [31:0] ox, logic signed [31:0] oy,
                                           logic signed [31:0] oz);
    longint dx, dy, dz, sy, cy, sp, cp, sr, cr, x1, y1, y2, z2, x3, z3, hx, hy;
    longint unsigned ax, ay, az, vd;
    logic [15:0] yaw_a;
    pixel_t p;
    p = '0;
    vd = view_dist;
    dx = longint'(ox) - longint'(cam_pos[0]);
    dy = longint'(oy) - longint'(cam_pos[1]);
    dz = longint'(oz) - longint'(cam_pos[2]);
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    az = (dz < 0) ? -dz : dz;
    if (ax > vd || ay > vd || az > vd) return p;
    if (ax * ax + ay * ay + az * az > vd * vd) return p;
    yaw_a = 16'h4000 - cam_ang[0];
    sy = bin_sin(yaw_a);
    cy = bin_sin(yaw_a + 16'h4000);
    sp = bin_sin(cam_ang[1]);
    cp = bin_sin(cam_ang[1] + 16'h4000);
    sr = bin_sin(cam_ang[2]);
    cr = bin_sin(cam_ang[2] + 16'h4000);
    x1 = q15_round(dx * cy - dy * sy);
    y1 = q15_round(dx * sy + dy * cy);
    y2 = q15_round(y1 * cp - dz * sp);
    z2 = q15_round(y1 * sp + dz * cp);
    x3 = q15_round(x1 * cr - z2 * sr);
    z3 = q15_round(x1 * sr + z2 * cr);
    if (y2 <= 6554) return p;
    hx = screen_ctr[31:16];
    hy = screen_ctr[15:0];
    p.vis = 1'b1;
    p.sx  = clamp16(hx + div_nearest(4 * hy * x3, 3 * y2));
    p.sy  = clamp16(hy - div_nearest(4 * hy * z3, 3 * y2));
    return p;
  endfunction

  // register write: setup cycle then access cycle
  task automatic write_reg(cpp_reg_e r, logic [31:0] val);
    @(negedge clk_i);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = PaddrW'(r) << 2; pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    case (r)
      REG_CAM_X:     cam_pos[0] = val;
      REG_CAM_Y:     cam_pos[1] = val;
      REG_CAM_Z:     cam_pos[2] = val;
      REG_YAW:       cam_ang[0] = val[15:0];
      REG_PITCH:     cam_ang[1] = val[15:0];
      REG_ROLL:      cam_ang[2] = val[15:0];
      REG_VIEW_DIST: view_dist  = val[23:0];
      REG_SCREEN:    screen_ctr = val;
      default: ;
    endcase
  endtask

  task automatic send_point(logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] z, bit typed, pixel_t pix);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_in_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {z, y, x};
    do @(posedge clk_i); while (!s_axis_tready);
    pixel_q.push_back(typed ? pix : project_point(x, y, z));
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin
    pixel_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[31:16]};
      if (pixel_q.size() == 0) begin
        $display("%0t: unexpected word vis=%0b sx=%0d sy=%0d", $realtime,
                 got.vis, got.sx, got.sy);
        errors++;
      end else begin
        want = pixel_q.pop_front();
        if (got.vis !== want.vis) begin
          $display("%0t: visible expected %0b got %0b", $realtime, want.vis, got.vis);
          errors++;
        end
        if (got.sx !== want.sx) begin
          $display("%0t: screen_x expected %0d got %0d", $realtime, want.sx, got.sx);
          errors++;
        end
        if (got.sy !== want.sy) begin
          $display("%0t: screen_y expected %0d got %0d", $realtime, want.sy, got.sy);
          errors++;
        end
      end
    end
  end

  // watchdog on handshake progress
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver backpressure
  always @(negedge clk_i) begin
    m_axis_tready = ($urandom_range(99) >= stall_out_pct);
  end

  task automatic set_row(int i, logic signed [31:0] x, logic signed [31:0] y,
                         logic signed [31:0] z, bit typed, pixel_t pix);
    dir_rows[i] = {x, y, z, typed, pix};
  endtask

  initial begin
    logic signed [31:0] ox, oy, oz;
    longint span;
    pixel_t nopix;
    errors = 0; quiet_cycles = 0;
    idle_in_pct = 0; stall_out_pct = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    s_axis_tvalid = 0; s_axis_tdata = '0; m_axis_tready = 1'b1;
    cam_pos = '{0, 0, 0}; cam_ang = '{0, 0, 0};
    view_dist = ViewDistRst; screen_ctr = ScreenRst;
    fill_sine_table();
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed points at reset settings; camera looks along +x
    nopix = '0;
    set_row(0,  32'sd655360, 0, 0, 1, '{1'b1, 16'sd512, 16'sd384});
    set_row(1,  0, 0, 0, 1, nopix);                             // at the camera
    set_row(2,  32'sd3342336, 0, 0, 1, nopix);                  // past view distance
    set_row(3,  32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1, nopix);
    set_row(4,  32'sh80000000, 32'sh80000000, 32'sh80000000, 1, nopix);
    set_row(5,  0, 32'sd655360, 0, 1, nopix);                   // zero depth
    set_row(6,  -32'sd655360, 0, 0, 1, nopix);                  // behind
    set_row(7,  32'sd6554, 0, 0, 1, nopix);                     // depth exactly 0.1
    set_row(8,  32'sd6555, 0, 0, 0, nopix);
    set_row(9,  32'sd13107, 32'sd2621440, 0, 0, nopix);         // saturates
    set_row(10, 32'sd655360, 0, 32'sd655360, 0, nopix);
    set_row(11, 32'sd3276800, 0, 0, 0, nopix);                  // on the range edge
    set_row(12, 32'sd2000000, 32'sd2000000, 32'sd2000000, 1, nopix); // sphere miss
    foreach (dir_rows[i])
      send_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z,
                 dir_rows[i].typed, dir_rows[i].pix);
    drain();

    // random phases with fresh camera settings and handshake pressure
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        1: begin
          write_reg(REG_CAM_X, 32'h7fffffff); write_reg(REG_CAM_Y, 32'h7fffffff);
          write_reg(REG_CAM_Z, 32'h7fffffff);
          write_reg(REG_YAW, 32'h8000); write_reg(REG_PITCH, 32'h7fff);
          write_reg(REG_ROLL, 32'h8000);
          write_reg(REG_VIEW_DIST, 32'hffffff); write_reg(REG_SCREEN, 32'hffffffff);
        end
        2: begin
          write_reg(REG_CAM_X, 32'h80000000); write_reg(REG_CAM_Y, 32'h80000000);
          write_reg(REG_CAM_Z, 32'h80000000);
          write_reg(REG_YAW, 32'h7fff); write_reg(REG_PITCH, 32'h8000);
          write_reg(REG_ROLL, 32'h7fff);
          write_reg(REG_VIEW_DIST, 32'h0); write_reg(REG_SCREEN, 32'h0);
        end
        default: if (ph != 0) begin
          write_reg(REG_CAM_X, $urandom()); write_reg(REG_CAM_Y, $urandom());
          write_reg(REG_CAM_Z, $urandom());
          write_reg(REG_YAW, $urandom()); write_reg(REG_PITCH, $urandom());
          write_reg(REG_ROLL, $urandom());
          write_reg(REG_VIEW_DIST, $urandom_range(32'h1000, 32'h400000));
          write_reg(REG_SCREEN, {16'($urandom_range(1024)), 16'($urandom_range(1024))});
        end
      endcase
      case (ph % 4)
        0: begin idle_in_pct = 0;  stall_out_pct = 0;  end
        1: begin idle_in_pct = 54; stall_out_pct = 0;  end
        2: begin idle_in_pct = 0;  stall_out_pct = 54; end
        default: begin idle_in_pct = 16; stall_out_pct = 16; end
      endcase
      span = longint'(view_dist) + longint'(view_dist) / 8 + 1;
      for (int n = 0; n < PhaseItems; n++) begin
        if ($urandom_range(99) < 85) begin
          // points around the camera, offsets up to about 9/8 of the view distance
          ox = cam_pos[0] + 32'(longint'($urandom_range(2 * span)) - span);
          oy = cam_pos[1] + 32'(longint'($urandom_range(2 * span)) - span);
          oz = cam_pos[2] + 32'(longint'($urandom_range(2 * span)) - span);
        end else begin
          ox = $urandom(); oy = $urandom(); oz = $urandom();
        end
        send_point(ox, oy, oz, 0, nopix);
      end
      drain();
    end

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### filelist.f
design/cpp_pkg.sv
design/camera_point_projection.sv
verif/tb_camera_point_projection.sv
